>>> rtl/modbus_rtu_slave_frame_handler_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU slave frame handler
// Shared property forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_MACROS_SVH
`define MODBUS_RTU_SLAVE_FRAME_HANDLER_TOP_MACROS_SVH

// same-cycle implication
`define MRTU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// Types, constants and the CRC-16 byte step shared by the frame handler.
// ----------------------------------------------------------------------------
package mrtu_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FN_WRITE_COIL = 8'h05;
    localparam logic [7:0]  FN_READ_HOLD  = 8'h03;
    localparam logic [15:0] COIL_ON_VAL   = 16'hFF00;
    localparam logic [15:0] COIL_OFF_VAL  = 16'h0000;
    localparam int          HDR_BYTES     = 6;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_COIL_BASE  = 1'b1;

    // input item kinds
    localparam logic ACT_RX_BYTE  = 1'b0;
    localparam logic ACT_REG_WR   = 1'b1;

    // result kinds
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_RELAY = 1'b1;

    typedef struct packed {
        logic               action;
        logic [7:0]         rx_byte;
        logic               end_of_frame;
        logic [5:0]         reg_index;
        logic signed [15:0] reg_value;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [2:0] relay_index;
        logic       relay_on;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_COIL  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // one unit of work handed from front to back
    typedef struct packed {
        op_t                  op;
        logic [5:0][7:0]      hdr;
        logic                 relay_ok;
        logic [2:0]           relay_idx;
        logic                 relay_on;
        logic [5:0]           wr_idx;
        logic [15:0]          wr_val;
    } job_t;

    // reflected CRC-16 over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

>>> rtl/mrtu_front.sv
// ----------------------------------------------------------------------------
// mrtu_front
// Takes input transactions, tracks the frame and CRC, classifies finished
// frames and queues the work for the back end.
// ----------------------------------------------------------------------------
module mrtu_front #(
    parameter int TABLE_DEPTH = 64,
    parameter int FRAME_BYTES = 64,
    parameter int MAX_READ    = 29,
    parameter int RELAY_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  mrtu_pkg::in_item_t item,
    input  logic [7:0]        own_addr,
    input  logic [15:0]       coil_base,
    output logic              job_push,
    output mrtu_pkg::job_t    job
);

    localparam int LW = $clog2(FRAME_BYTES + 2);

    logic [15:0]     crc_reg, crc_next, crc_upd;
    logic [LW-1:0]   len_reg, len_next, len_inc;
    logic [5:0][7:0] hdr_reg, hdr_new;
    logic [1:0][7:0] trl_reg, trl_new;
    logic [15:0]     rx_crc, addr, val, rel;
    logic            frame_ok, is_coil, is_read, byte_acc;

    assign byte_acc = accept && (item.action == mrtu_pkg::ACT_RX_BYTE);

    // per-byte frame update
    always_comb
    begin
        crc_upd = (len_reg >= LW'(2)) ? mrtu_pkg::crc16_byte(crc_reg, trl_reg[0]) : crc_reg;
        trl_new = {item.rx_byte, trl_reg[1]};
        hdr_new = hdr_reg;
        if (len_reg < LW'(mrtu_pkg::HDR_BYTES))
        begin
            hdr_new[len_reg[2:0]] = item.rx_byte;
        end
        len_inc = (len_reg <= LW'(FRAME_BYTES)) ? len_reg + LW'(1) : len_reg;
        crc_next = crc_reg;
        len_next = len_reg;
        if (byte_acc)
        begin
            crc_next = item.end_of_frame ? mrtu_pkg::CRC_INIT : crc_upd;
            len_next = item.end_of_frame ? '0 : len_inc;
        end
    end

    // frame classification at the last byte
    always_comb
    begin
        rx_crc   = {item.rx_byte, trl_reg[1]};
        addr     = {hdr_new[2], hdr_new[3]};
        val      = {hdr_new[4], hdr_new[5]};
        rel      = addr - coil_base;
        frame_ok = (len_inc >= LW'(mrtu_pkg::HDR_BYTES)) && (len_inc <= LW'(FRAME_BYTES))
                   && (rx_crc == crc_upd) && (hdr_new[0] == own_addr);
        is_coil  = hdr_new[1] == mrtu_pkg::FN_WRITE_COIL;
        is_read  = (hdr_new[1] == mrtu_pkg::FN_READ_HOLD) && (val != 16'd0)
                   && (val <= 16'(MAX_READ));

        job           = '0;
        job.hdr       = hdr_new;
        job.relay_ok  = (rel < 16'(RELAY_COUNT))
                        && ((val == mrtu_pkg::COIL_ON_VAL) || (val == mrtu_pkg::COIL_OFF_VAL));
        job.relay_idx = rel[2:0];
        job.relay_on  = val == mrtu_pkg::COIL_ON_VAL;
        job.wr_idx    = item.reg_index;
        job.wr_val    = item.reg_value;
        job_push      = 1'b0;
        if (accept && (item.action == mrtu_pkg::ACT_REG_WR))
        begin
            job.op   = mrtu_pkg::OP_WRITE;
            job_push = 11'(item.reg_index) < 11'(TABLE_DEPTH);
        end
        else if (is_coil)
        begin
            job.op   = mrtu_pkg::OP_COIL;
            job_push = byte_acc && item.end_of_frame && frame_ok;
        end
        else
        begin
            job.op   = mrtu_pkg::OP_READ;
            job_push = byte_acc && item.end_of_frame && frame_ok && is_read;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= mrtu_pkg::CRC_INIT;
            len_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            len_reg <= len_next;
        end
    end

    // header and trailing bytes
    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            hdr_reg <= hdr_new;
            trl_reg <= trl_new;
        end
    end

endmodule

>>> rtl/mrtu_jobq.sv
// ----------------------------------------------------------------------------
// mrtu_jobq
// Two-entry queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mrtu_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mrtu_pkg::job_t wdata,
    input  logic           pop,
    output mrtu_pkg::job_t rdata,
    output logic           q_empty,
    output logic           q_full
);

    mrtu_pkg::job_t slot_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_push, do_pop;

    assign q_empty = cnt_reg == 2'd0;
    assign q_full  = cnt_reg == 2'd2;
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign rdata   = slot_reg[rptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/mrtu_back.sv
// ----------------------------------------------------------------------------
// mrtu_back
// Carries out queued jobs: holding register writes, coil echoes and register
// reads. Owns the register table and the result output register.
// ----------------------------------------------------------------------------
module mrtu_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  mrtu_pkg::job_t     job,
    output logic               q_pop,
    output logic               clearing,
    output logic               empty,
    input  logic               pop,
    output mrtu_pkg::out_item_t out_item
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RELAY, S_HDR, S_RD_HEAD, S_RD_HI, S_RD_LO, S_CRC_LO, S_CRC_HI
    } state_t;

    state_t              state_reg, state_next;
    mrtu_pkg::job_t      job_reg, job_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [15:0]         crc_reg, crc_next;
    logic [16:0]         addr_reg, addr_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    mrtu_pkg::out_item_t out_reg, out_next;
    logic [15:0]         rdata_reg;
    logic                inrange_reg;
    logic [15:0]         mem [TABLE_DEPTH];
    logic                adv, emit, mem_we, mem_re;
    logic [AW-1:0]       wa;
    logic [15:0]         wd;
    logic [16:0]         ra;
    logic [7:0]          eb;
    logic [15:0]         rd_val;

    assign adv      = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;
    assign clearing = state_reg == S_CLEAR;
    assign rd_val   = inrange_reg ? rdata_reg : 16'd0;

    // job sequencing and result generation
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        clr_next   = clr_reg;
        out_next   = out_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wa         = AW'(job.wr_idx);
        wd         = job.wr_val;
        ra         = {1'b0, job.hdr[2], job.hdr[3]};
        eb         = 8'h00;
        out_valid_next = out_valid_reg && !pop;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                wa       = clr_reg;
                wd       = 16'd0;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == TABLE_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = job;
                    cnt_next = '0;
                    crc_next = mrtu_pkg::CRC_INIT;
                    unique case (job.op)
                        mrtu_pkg::OP_WRITE: mem_we = 1'b1;
                        mrtu_pkg::OP_COIL:  state_next = job.relay_ok ? S_RELAY : S_HDR;
                        mrtu_pkg::OP_READ:
                        begin
                            mem_re     = 1'b1;
                            addr_next  = ra;
                            state_next = S_RD_HEAD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RELAY:
            begin
                if (adv)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.kind        = mrtu_pkg::KIND_RELAY;
                    out_next.relay_index = job_reg.relay_idx;
                    out_next.relay_on    = job_reg.relay_on;
                    state_next           = S_HDR;
                end
            end
            S_HDR:
            begin
                eb = job_reg.hdr[cnt_reg[2:0]];
                if (adv)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'(mrtu_pkg::HDR_BYTES - 1))
                    begin
                        state_next = S_CRC_LO;
                    end
                end
            end
            S_RD_HEAD:
            begin
                case (cnt_reg[1:0])
                    2'd0:    eb = job_reg.hdr[0];
                    2'd1:    eb = mrtu_pkg::FN_READ_HOLD;
                    default: eb = {job_reg.hdr[5][6:0], 1'b0};
                endcase
                if (adv)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd2)
                    begin
                        cnt_next   = '0;
                        state_next = S_RD_HI;
                    end
                end
            end
            S_RD_HI:
            begin
                eb = rd_val[15:8];
                if (adv)
                begin
                    emit       = 1'b1;
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                eb = rd_val[7:0];
                ra = addr_reg + 17'd1;
                if (adv)
                begin
                    emit      = 1'b1;
                    mem_re    = 1'b1;
                    addr_next = ra;
                    cnt_next  = cnt_reg + 7'd1;
                    state_next = (cnt_reg + 7'd1 == job_reg.hdr[5][6:0]) ? S_CRC_LO : S_RD_HI;
                end
            end
            S_CRC_LO:
            begin
                if (adv)
                begin
                    out_valid_next   = 1'b1;
                    out_next         = '0;
                    out_next.tx_byte = crc_reg[7:0];
                    state_next       = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                if (adv)
                begin
                    out_valid_next   = 1'b1;
                    out_next         = '0;
                    out_next.tx_byte = crc_reg[15:8];
                    out_next.last    = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // plain response byte, folded into the response CRC
        if (emit)
        begin
            out_valid_next   = 1'b1;
            out_next         = '0;
            out_next.kind    = mrtu_pkg::KIND_TX;
            out_next.tx_byte = eb;
            crc_next         = mrtu_pkg::crc16_byte(crc_reg, eb);
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        cnt_reg  <= cnt_next;
        crc_reg  <= crc_next;
        addr_reg <= addr_next;
    end

    // holding register table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wa] <= wd;
        end
        if (mem_re)
        begin
            rdata_reg   <= mem[ra[AW-1:0]];
            inrange_reg <= ra < 17'(TABLE_DEPTH);
        end
    end

endmodule

>>> rtl/modbus_rtu_slave_frame_handler_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_frame_handler_top
// Modbus RTU slave: frame checking, coil writes and holding register reads.
// ----------------------------------------------------------------------------
// Each input transaction (a received byte or a local table write) is taken by
// the front end; finished frames and table writes pass through a two-entry
// job queue to the back end, which sends one result per cycle through its
// output register while pop is held and a job is in progress. A coil frame
// thus yields up to 9 results and a read frame 5 + 2*count results, one per
// cycle after the job start; full rises when the job queue holds two jobs or
// while the table is cleared. After reset the register table is cleared one
// entry a cycle, so the block reports full until the clear is done.
// ----------------------------------------------------------------------------
`include "modbus_rtu_slave_frame_handler_top_macros.svh"

module modbus_rtu_slave_frame_handler_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int FRAME_BYTES = 64,
    parameter int MAX_READ    = 29,
    parameter int RELAY_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mrtu_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output mrtu_pkg::out_item_t out_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [7:0]     slave_addr_reg;
    logic [15:0]    coil_base_reg;
    logic           accept, job_push, q_pop, q_empty, q_full, clearing;
    mrtu_pkg::job_t job_in, job_out;

    assign full   = q_full || clearing;
    assign accept = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd1;
            coil_base_reg  <= 16'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrtu_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                mrtu_pkg::CFG_COIL_BASE:  coil_base_reg  <= cfg_data;
            endcase
        end
    end

    mrtu_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES),
        .MAX_READ    (MAX_READ),
        .RELAY_COUNT (RELAY_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_item),
        .own_addr  (slave_addr_reg),
        .coil_base (coil_base_reg),
        .job_push  (job_push),
        .job       (job_in)
    );

    mrtu_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .wdata   (job_in),
        .pop     (q_pop),
        .rdata   (job_out),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    mrtu_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .job      (job_out),
        .q_pop    (q_pop),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // checks
    `MRTU_ASSERT_NOW(a_clear_blocks, clearing, full, "input taken during table clear")
    `MRTU_ASSERT_NOW(a_relay_not_last, !empty && (out_item.kind == mrtu_pkg::KIND_RELAY),
        !out_item.last && (out_item.tx_byte == 8'h00), "relay command ends a response")
    `MRTU_ASSERT_NEXT(a_no_lost_job, job_push && !q_full, !q_empty, "job dropped by queue")

endmodule

>>> test/modbus_rtu_slave_frame_handler_top_tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU slave frame handler testbench
// Sends received frames and local table writes through the input queue port
// and checks every response byte and relay command against a built-in
// predictor of the slave. Covers valid, short, long, bad-CRC and foreign
// frames, with and without idling on both sides.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_frame_handler_top_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int FRAME_BYTES = 64;
    localparam int MAX_READ    = 29;
    localparam int RELAY_COUNT = 8;
    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    mrtu_pkg::in_item_t  in_item;
    logic                empty;
    logic                pop;
    mrtu_pkg::out_item_t out_item;
    logic                cfg_we;
    logic                cfg_index;
    logic [15:0]         cfg_data;

    modbus_rtu_slave_frame_handler_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic [7:0]  station_addr;
    logic [15:0] relay_base;
    logic [15:0] frame_crc;
    int          frame_len;
    logic [7:0]  hdr_buf [6];
    logic [7:0]  tail_buf [2];
    logic [15:0] hold_regs [TABLE_DEPTH];

    mrtu_pkg::out_item_t response_q [$];
    int          error_count;
    int          sent_count;
    int          result_count;
    int          frames_answered;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("modbus_rtu_slave_frame_handler_top_tb: errors");
            $finish;
        end
    end

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void queue_tx(logic [7:0] b);
        mrtu_pkg::out_item_t r;
        r = '0;
        r.kind = mrtu_pkg::KIND_TX;
        r.tx_byte = b;
        response_q.push_back(r);
    endfunction

    // queue a response block followed by its CRC, low byte first
    function automatic void queue_block(logic [7:0] buf_b [$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (buf_b[i])
        begin
            c = crc_step(c, buf_b[i]);
            queue_tx(buf_b[i]);
        end
        queue_tx(c[7:0]);
        queue_tx(c[15:8]);
        response_q[$].last = 1'b1;
        frames_answered++;
    endfunction

    // decode a finished frame and queue its response
    function automatic void predict_frame_end();
        logic [15:0] addr;
        logic [15:0] val;
        logic [15:0] rel;
        logic [15:0] v;
        logic [7:0]  resp [$];
        mrtu_pkg::out_item_t r;
        int unsigned reg_no;
        if (frame_len < 6 || frame_len > FRAME_BYTES)
            return;
        if ({tail_buf[1], tail_buf[0]} != frame_crc || hdr_buf[0] != station_addr)
            return;
        addr = {hdr_buf[2], hdr_buf[3]};
        val  = {hdr_buf[4], hdr_buf[5]};
        if (hdr_buf[1] == mrtu_pkg::FN_WRITE_COIL)
        begin
            rel = addr - relay_base;
            if (rel < RELAY_COUNT &&
                (val == mrtu_pkg::COIL_ON_VAL || val == mrtu_pkg::COIL_OFF_VAL))
            begin
                r = '0;
                r.kind = mrtu_pkg::KIND_RELAY;
                r.relay_index = rel[2:0];
                r.relay_on = (val == mrtu_pkg::COIL_ON_VAL);
                response_q.push_back(r);
            end
            for (int i = 0; i < 6; i++)
                resp.push_back(hdr_buf[i]);
            queue_block(resp);
        end
        else if (hdr_buf[1] == mrtu_pkg::FN_READ_HOLD)
        begin
            if (val == 0 || val > MAX_READ)
                return;
            resp.push_back(hdr_buf[0]);
            resp.push_back(mrtu_pkg::FN_READ_HOLD);
            resp.push_back(8'(val * 2));
            for (int i = 0; i < val; i++)
            begin
                reg_no = addr + i;
                v = (reg_no < TABLE_DEPTH) ? hold_regs[reg_no] : 16'h0000;
                resp.push_back(v[15:8]);
                resp.push_back(v[7:0]);
            end
            queue_block(resp);
        end
    endfunction

    function automatic void predict_item(mrtu_pkg::in_item_t it);
        if (it.action == mrtu_pkg::ACT_REG_WR)
        begin
            hold_regs[it.reg_index] = it.reg_value;
            return;
        end
        if (frame_len >= 2)
            frame_crc = crc_step(frame_crc, tail_buf[0]);
        tail_buf[0] = tail_buf[1];
        tail_buf[1] = it.rx_byte;
        if (frame_len < 6)
            hdr_buf[frame_len] = it.rx_byte;
        if (frame_len <= FRAME_BYTES)
            frame_len++;
        if (it.end_of_frame)
        begin
            predict_frame_end();
            frame_crc = 16'hFFFF;
            frame_len = 0;
        end
    endfunction

    // drop push and scramble the payload while no transaction is offered
    task automatic release_input();
        push <= 1'b0;
        in_item.action <= 1'($urandom_range(1));
        in_item.rx_byte <= 8'($urandom);
    endtask

    // one input transaction; push stays high into the next one
    task automatic send_item(mrtu_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            release_input();
            @(negedge clk);
        end
        push <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(it);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic eof);
        mrtu_pkg::in_item_t it;
        it = '0;
        it.action = mrtu_pkg::ACT_RX_BYTE;
        it.rx_byte = b;
        it.end_of_frame = eof;
        it.reg_index = 6'($urandom);
        it.reg_value = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_reg_write(logic [5:0] idx, logic [15:0] val);
        mrtu_pkg::in_item_t it;
        it = '0;
        it.action = mrtu_pkg::ACT_REG_WR;
        it.rx_byte = 8'($urandom);
        it.end_of_frame = 1'($urandom);
        it.reg_index = idx;
        it.reg_value = val;
        send_item(it);
    endtask

    // send body bytes plus CRC; bad_crc flips a CRC bit
    task automatic send_frame(logic [7:0] body [$], bit bad_crc);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (body[i])
        begin
            c = crc_step(c, body[i]);
            send_byte(body[i], 1'b0);
        end
        if (bad_crc)
            c ^= 16'(1 << $urandom_range(15));
        send_byte(c[7:0], 1'b0);
        send_byte(c[15:8], 1'b1);
    endtask

    task automatic send_request(logic [7:0] addr, logic [7:0] fn, logic [15:0] a,
                                logic [15:0] v, bit bad_crc);
        logic [7:0] body [$];
        body = '{addr, fn, a[15:8], a[7:0], v[15:8], v[7:0]};
        send_frame(body, bad_crc);
    endtask

    // wait for all responses, then let the back end settle
    task automatic drain();
        release_input();
        while (response_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_config(logic idx, logic [15:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == mrtu_pkg::CFG_SLAVE_ADDR)
            station_addr = val[7:0];
        else
            relay_base = val;
    endtask

    // receive side: random stall, compare against oldest expectation
    always @(negedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        mrtu_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            result_count++;
            if (response_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result got %h", $time, out_item);
            end
            else
            begin
                want = response_q.pop_front();
                if (out_item.kind !== want.kind || out_item.tx_byte !== want.tx_byte ||
                    out_item.last !== want.last ||
                    out_item.relay_index !== want.relay_index ||
                    out_item.relay_on !== want.relay_on)
                begin
                    error_count++;
                    $display("%0t: mismatch expected %h actual %h", $time, want, out_item);
                end
            end
        end
    end

    task automatic test_register_writes();
        send_reg_write(6'd0, 16'h8000);
        send_reg_write(6'd63, 16'h7FFF);
        send_reg_write(6'd1, 16'hFFFF);
        send_reg_write(6'd2, 16'h0000);
        send_reg_write(6'd3, 16'h5AA5);
    endtask

    task automatic test_directed_frames();
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'd0, 16'd4, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'd62, 16'd3, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'hFFFF, 16'd2, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'd0, 16'd0, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'd0, 16'd30, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_READ_HOLD, 16'd5, 16'd29, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd16, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd23, mrtu_pkg::COIL_OFF_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd24, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd15, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd17, 16'h1234, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd18, mrtu_pkg::COIL_ON_VAL, 1'b1);
        send_request(8'd2, mrtu_pkg::FN_WRITE_COIL, 16'd18, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd1, 8'h06, 16'd18, mrtu_pkg::COIL_ON_VAL, 1'b0);
        // short frame: three bytes
        send_byte(8'h01, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hFF, 1'b1);
        // single byte frame
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_long_frames();
        logic [7:0] body [$];
        // exactly the buffer length is still taken
        body = '{8'd1, mrtu_pkg::FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd2};
        while (body.size() < FRAME_BYTES - 2)
            body.push_back(8'($urandom));
        send_frame(body, 1'b0);
        body.push_back(8'($urandom));
        send_frame(body, 1'b0);
        repeat (8) body.push_back(8'($urandom));
        send_frame(body, 1'b0);
    endtask

    task automatic test_config_extremes();
        write_config(mrtu_pkg::CFG_SLAVE_ADDR, 16'd247);
        write_config(mrtu_pkg::CFG_COIL_BASE, 16'hFFFC);
        send_request(8'd247, mrtu_pkg::FN_WRITE_COIL, 16'hFFFF, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd247, mrtu_pkg::FN_WRITE_COIL, 16'h0003, mrtu_pkg::COIL_OFF_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'h0003, mrtu_pkg::COIL_OFF_VAL, 1'b0);
        write_config(mrtu_pkg::CFG_COIL_BASE, 16'd0);
        write_config(mrtu_pkg::CFG_SLAVE_ADDR, 16'd1);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd7, mrtu_pkg::COIL_ON_VAL, 1'b0);
        send_request(8'd1, mrtu_pkg::FN_WRITE_COIL, 16'd0, mrtu_pkg::COIL_OFF_VAL, 1'b0);
    endtask

    // mostly well-formed requests, some noise and corruption
    task automatic test_random(int n_items);
        int start;
        int sel;
        logic [7:0]  addr;
        logic [15:0] a;
        logic [15:0] v;
        logic [7:0]  body [$];
        start = sent_count;
        while (sent_count - start < n_items)
        begin
            sel = $urandom_range(99);
            addr = ($urandom_range(9) == 0) ? 8'($urandom) : station_addr;
            if (sel < 20)
                send_reg_write(6'($urandom), 16'($urandom));
            else if (sel < 50)
            begin
                a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(70));
                v = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
                                             : 16'($urandom_range(1, 4));
                send_request(addr, mrtu_pkg::FN_READ_HOLD, a, v, $urandom_range(9) == 0);
            end
            else if (sel < 85)
            begin
                a = ($urandom_range(3) == 0) ? 16'($urandom)
                                             : relay_base + 16'($urandom_range(9));
                case ($urandom_range(2))
                    0: v = mrtu_pkg::COIL_ON_VAL;
                    1: v = mrtu_pkg::COIL_OFF_VAL;
                    default: v = 16'($urandom);
                endcase
                send_request(addr, mrtu_pkg::FN_WRITE_COIL, a, v, $urandom_range(9) == 0);
            end
            else
            begin
                body.delete();
                repeat ($urandom_range(1, 10))
                    body.push_back(8'($urandom));
                foreach (body[i])
                    send_byte(body[i], i == body.size() - 1);
            end
        end
    endtask

    task automatic set_idling(int s, int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = mrtu_pkg::CFG_SLAVE_ADDR;
        cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        sent_count = 0;
        result_count = 0;
        frames_answered = 0;
        station_addr = 8'd1;
        relay_base = 16'd16;
        frame_crc = 16'hFFFF;
        frame_len = 0;
        foreach (hold_regs[i])
            hold_regs[i] = '0;
        foreach (hdr_buf[i])
            hdr_buf[i] = '0;
        tail_buf[0] = '0;
        tail_buf[1] = '0;
        set_idling(0, 0);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_register_writes();
        test_directed_frames();
        test_long_frames();
        test_config_extremes();

        write_config(mrtu_pkg::CFG_SLAVE_ADDR, 16'd1);
        write_config(mrtu_pkg::CFG_COIL_BASE, 16'd16);
        set_idling(0, 0);
        test_random(22);
        set_idling(62, 0);
        test_random(22);
        write_config(mrtu_pkg::CFG_SLAVE_ADDR, 16'd100);
        write_config(mrtu_pkg::CFG_COIL_BASE, 16'd40000);
        set_idling(0, 62);
        test_random(22);
        set_idling(9, 9);
        test_random(22);
        write_config(mrtu_pkg::CFG_SLAVE_ADDR, 16'd247);
        write_config(mrtu_pkg::CFG_COIL_BASE, 16'hFFFF);
        set_idling(0, 0);
        test_random(22);

        drain();
        $display("sent %0d input transactions, checked %0d results over %0d answered frames",
                 sent_count, result_count, frames_answered);
        if (error_count == 0)
            $display("modbus_rtu_slave_frame_handler_top_tb: clean");
        else
            $display("modbus_rtu_slave_frame_handler_top_tb: errors");
        $finish;
    end

endmodule
